// File: rtl/core/bam_pkg.sv
// Shared types, constants and codes for the block bitmap allocator.
package bam_pkg;

  localparam int BAM_MAX_BLOCKS_DEF = 8192;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 13;
  localparam int CNT_W  = 14;
  localparam int STAT_W = 2;
  localparam int WORD_W = 8;

  localparam int MIN_BLOCKS = 32;

  localparam logic [CNT_W-1:0]  RESET_BLOCKS  = 14'd32;
  localparam logic [CNT_W-1:0]  RESET_FREE    = 14'd30;
  localparam logic [CNT_W-1:0]  RESERVED_CNT  = 14'd2;
  localparam logic [CNT_W-1:0]  CNT_MAX       = 14'h3FFF;
  localparam logic [WORD_W-1:0] RESERVED_WORD = 8'hC0;
  localparam logic [WORD_W-1:0] FULL_WORD     = 8'hFF;
  localparam logic [WORD_W-1:0] TOP_BIT       = 8'h80;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NONE  = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_MARK_USED = 2'd0,
    OP_MARK_FREE = 2'd1,
    OP_FIND      = 2'd2,
    OP_FORMAT    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_RD,
    S_MARK_WR,
    S_FIND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              bit_set;
    logic              zero_hit;
    logic [2:0]        zero_pos;
    logic [WORD_W-1:0] new_word;
  } word_res_t;

endpackage

// File: rtl/core/bam_if.sv
// Valid/ready channel interfaces for configuration, request and response transactions.
interface bam_cfg_if import bam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] block_count;

  modport source (output valid, output block_count, input ready);
  modport sink (input valid, input block_count, output ready);
endinterface

interface bam_in_if import bam_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] block_index;

  modport source (output valid, output operation, output block_index, input ready);
  modport sink (input valid, input operation, input block_index, output ready);
endinterface

interface bam_out_if import bam_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  found_block;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, output status, output found_block, output free_count,
                  input ready);
  modport sink (input valid, input status, input found_block, input free_count,
                output ready);
endinterface

// File: rtl/core/bam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/bam_word_unit.sv
// Shared bitmap word unit: bit test, bit set/clear and first-free search.
module bam_word_unit import bam_pkg::*; (
  input  logic [WORD_W-1:0] word,
  input  logic [2:0]        bit_sel,
  input  logic              set_bit,
  output word_res_t         res
);

  always_comb begin
    logic [WORD_W-1:0] mask;
    mask         = TOP_BIT >> bit_sel;
    res.bit_set  = |(word & mask);
    res.new_word = set_bit ? (word | mask) : (word & ~mask);
    res.zero_hit = (word != FULL_WORD);
    res.zero_pos = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (!word[j]) begin
        res.zero_pos = 3'(WORD_W - 1 - j);
      end
    end
  end

endmodule

// File: rtl/core/block_bitmap_allocator_unit.sv
// Block bitmap allocator top level: sequencer, counters and bitmap storage.
// Out-of-range marks and finds with a zero free counter respond directly; a mark reads,
// then writes back its bitmap word; a find scans up to block_count/8 words and a format
// clears every bitmap word; the bitmap RAM is scanned or swept one word per cycle.
// One request at a time; in_chan.ready is high only while idle.
// Reset: synchronous active low; then a clearing pass over every bitmap word with ready low.
module block_bitmap_allocator_unit import bam_pkg::*; #(
  parameter int MAX_BLOCKS = BAM_MAX_BLOCKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  bam_cfg_if.sink     cfg_chan,
  bam_in_if.sink      in_chan,
  bam_out_if.source   out_chan
);

  localparam int MAP_WORDS = (MAX_BLOCKS + 7) / 8;
  localparam int AW        = $clog2(MAP_WORDS);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  bc_r, bc_nxt;
  logic [AW:0]       rd_cnt_r, rd_cnt_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]     chk_addr_r, chk_addr_nxt;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              fmt_r, fmt_nxt;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_found_r, res_found_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_found_r, out_found_nxt;
  logic [CNT_W-1:0]  out_free_r, out_free_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  word_res_t         wres;

  logic              in_acc;
  logic              slot_free;
  logic [CNT_W-1:0]  n_sat;
  logic              out_of_range;
  logic [AW:0]       words;
  logic              issue;
  logic              clr_last;
  logic [AW-1:0]     mark_addr;

  assign in_acc       = in_chan.valid && in_chan.ready;
  assign slot_free    = !out_valid_r || out_chan.ready;
  assign n_sat        = (bc_r < CNT_W'(MIN_BLOCKS)) ? CNT_W'(MIN_BLOCKS) :
                        ((32'(bc_r) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : bc_r);
  assign out_of_range = {1'b0, in_chan.block_index} >= n_sat;
  assign words        = (AW+1)'(n_r >> 3);
  assign issue        = rd_cnt_r < words;
  assign clr_last     = clr_cnt_r == AW'(MAP_WORDS - 1);
  assign mark_addr    = AW'(32'(idx_r) >> 3);

  assign in_chan.ready        = (state_r == S_IDLE);
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.found_block = out_found_r;
  assign out_chan.free_count  = out_free_r;

  bam_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bam_word_unit u_word (
    .word    (ram_rdata),
    .bit_sel (idx_r[2:0]),
    .set_bit (op_r == OP_MARK_USED),
    .res     (wres)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_last) begin
          state_nxt = fmt_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_chan.operation))
            OP_MARK_USED, OP_MARK_FREE: state_nxt = out_of_range ? S_DONE : S_MARK_RD;
            OP_FIND:   state_nxt = (free_r == '0) ? S_DONE : S_FIND;
            OP_FORMAT: state_nxt = S_CLEAR;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_MARK_RD: state_nxt = S_MARK_WR;
      S_MARK_WR: state_nxt = S_DONE;
      S_FIND: begin
        if ((chk_vld_r && wres.zero_hit) || (!chk_vld_r && !issue)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    free_nxt       = free_r;
    bc_nxt         = bc_r;
    rd_cnt_nxt     = rd_cnt_r;
    chk_vld_nxt    = chk_vld_r;
    chk_addr_nxt   = chk_addr_r;
    clr_cnt_nxt    = clr_cnt_r;
    fmt_nxt        = fmt_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_free_nxt   = out_free_r;
    ram_we         = 1'b0;
    ram_waddr      = clr_cnt_r;
    ram_wdata      = '0;
    ram_raddr      = '0;

    if (cfg_chan.valid && cfg_chan.ready) begin
      bc_nxt = cfg_chan.block_count;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = (clr_cnt_r == '0) ? RESERVED_WORD : '0;
        clr_cnt_nxt = clr_last ? '0 : clr_cnt_r + 1'b1;
        if (clr_last && fmt_r) begin
          fmt_nxt        = 1'b0;
          free_nxt       = n_r - RESERVED_CNT;
          res_status_nxt = STATUS_OK;
          res_found_nxt  = '0;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = op_t'(in_chan.operation);
          idx_nxt        = in_chan.block_index;
          n_nxt          = n_sat;
          rd_cnt_nxt     = '0;
          chk_vld_nxt    = 1'b0;
          clr_cnt_nxt    = '0;
          res_status_nxt = STATUS_OK;
          res_found_nxt  = '0;
          case (op_t'(in_chan.operation))
            OP_MARK_USED, OP_MARK_FREE: begin
              if (out_of_range) begin
                res_status_nxt = STATUS_RANGE;
              end
            end
            OP_FIND: begin
              if (free_r == '0) begin
                res_status_nxt = STATUS_NONE;
              end
            end
            OP_FORMAT: fmt_nxt = 1'b1;
            default: fmt_nxt = fmt_r;
          endcase
        end
      end
      S_MARK_RD: begin
        ram_raddr = mark_addr;
      end
      S_MARK_WR: begin
        ram_waddr = mark_addr;
        ram_wdata = wres.new_word;
        if (op_r == OP_MARK_USED && !wres.bit_set) begin
          ram_we = 1'b1;
          if (free_r != '0) begin
            free_nxt = free_r - 1'b1;
          end
        end else if (op_r == OP_MARK_FREE && wres.bit_set) begin
          ram_we = 1'b1;
          if (free_r != CNT_MAX) begin
            free_nxt = free_r + 1'b1;
          end
        end
      end
      S_FIND: begin
        ram_raddr    = rd_cnt_r[AW-1:0];
        chk_vld_nxt  = issue;
        chk_addr_nxt = rd_cnt_r[AW-1:0];
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end
        if (chk_vld_r && wres.zero_hit) begin
          res_status_nxt = STATUS_OK;
          res_found_nxt  = IDX_W'(32'(chk_addr_r) * 8 + 32'(wres.zero_pos));
        end else if (!chk_vld_r && !issue) begin
          res_status_nxt = STATUS_NONE;
          res_found_nxt  = '0;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_free_nxt   = free_r;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      fmt_r       <= 1'b0;
      free_r      <= RESET_FREE;
      bc_r        <= RESET_BLOCKS;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      fmt_r       <= fmt_nxt;
      free_r      <= free_nxt;
      bc_r        <= bc_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    chk_addr_r   <= chk_addr_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_free_r   <= out_free_nxt;
  end

endmodule

// File: rtl/core/bam_checker.sv
// Port-level assertions for the block bitmap allocator, bound to the top level.
module bam_port_checker import bam_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [STAT_W-1:0] out_status,
  input logic [IDX_W-1:0]  out_found_block,
  input logic [CNT_W-1:0]  out_free_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_found_block) &&
                                $stable(out_free_count))
    else $error("response payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STATUS_OK |-> out_found_block == '0)
    else $error("found block nonzero on failed transaction");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == STATUS_OK || out_status == STATUS_RANGE ||
                  out_status == STATUS_NONE)
    else $error("undefined status code");

endmodule

bind block_bitmap_allocator_unit bam_port_checker u_bam_port_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_status      (out_chan.status),
  .out_found_block (out_chan.found_block),
  .out_free_count  (out_chan.free_count)
);

// File: dv/bam_checker.sv
// Response checker for the block bitmap allocator: tracks the used-block map and compares responses.
`timescale 1ns / 1ps
module bam_checker import bam_pkg::*; #(
  parameter int MAX_BLOCKS = BAM_MAX_BLOCKS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bam_cfg_if   cfg_mon,
  bam_in_if    req_mon,
  bam_out_if   rsp_mon,
  output int   err_count,
  output int   pending,
  output int   checked
);

  localparam int MAP_WORDS = (MAX_BLOCKS + 7) / 8;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  found_block;
    logic [CNT_W-1:0]  free_count;
  } alloc_rsp_t;

  logic [WORD_W-1:0] map_shadow [MAP_WORDS];
  logic [CNT_W-1:0]  free_shadow;
  logic [CNT_W-1:0]  count_reg;
  alloc_rsp_t        rsp_q [$];

  function automatic int active_blocks();
    int n;
    n = int'(count_reg);
    if (n < MIN_BLOCKS) n = MIN_BLOCKS;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    return n;
  endfunction

  function automatic void clear_map();
    foreach (map_shadow[i]) map_shadow[i] = '0;
    map_shadow[0] = RESERVED_WORD;
  endfunction

  function automatic alloc_rsp_t apply_request(op_t op, logic [IDX_W-1:0] idx);
    alloc_rsp_t        r;
    int                n;
    int                w;
    logic [WORD_W-1:0] mask;
    bit                hit;
    n   = active_blocks();
    r   = '0;
    hit = 1'b0;
    case (op)
      OP_MARK_USED, OP_MARK_FREE: begin
        if (int'(idx) >= n) begin
          r.status = STATUS_RANGE;
        end else begin
          w    = int'(idx >> 3);
          mask = TOP_BIT >> idx[2:0];
          if (op == OP_MARK_USED && (map_shadow[w] & mask) == '0) begin
            map_shadow[w] = map_shadow[w] | mask;
            if (free_shadow != '0) free_shadow = free_shadow - 1'b1;
          end else if (op == OP_MARK_FREE && (map_shadow[w] & mask) != '0) begin
            map_shadow[w] = map_shadow[w] & ~mask;
            if (free_shadow != CNT_MAX) free_shadow = free_shadow + 1'b1;
          end
        end
      end
      OP_FIND: begin
        if (free_shadow != '0) begin
          for (int i = 0; i < n / 8 && i < MAP_WORDS && !hit; i++) begin
            for (int j = 0; j < WORD_W && !hit; j++) begin
              if (!map_shadow[i][WORD_W-1-j]) begin
                r.found_block = IDX_W'(i * WORD_W + j);
                hit           = 1'b1;
              end
            end
          end
        end
        if (!hit) r.status = STATUS_NONE;
      end
      default: begin
        clear_map();
        free_shadow = CNT_W'(n) - RESERVED_CNT;
      end
    endcase
    r.free_count = free_shadow;
    return r;
  endfunction

  function automatic void check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst_n) begin
      clear_map();
      free_shadow = RESET_FREE;
      count_reg   = RESET_BLOCKS;
      rsp_q.delete();
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: response with nothing expected: status=%0d found=%0d free=%0d",
                   $time, rsp_mon.status, rsp_mon.found_block, rsp_mon.free_count);
          err_count++;
        end else begin
          want = rsp_q.pop_front();
          checked++;
          check_field("status", want.status, rsp_mon.status);
          check_field("found_block", want.found_block, rsp_mon.found_block);
          check_field("free_count", want.free_count, rsp_mon.free_count);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) count_reg = cfg_mon.block_count;
      if (req_mon.valid && req_mon.ready)
        rsp_q.push_back(apply_request(op_t'(req_mon.operation), req_mon.block_index));
    end
    pending = rsp_q.size();
  end

endmodule

// File: dv/tb_block_bitmap_allocator_unit.sv
// Testbench top for the block bitmap allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_block_bitmap_allocator_unit;
  import bam_pkg::*;

  localparam int MAX_BLOCKS   = BAM_MAX_BLOCKS_DEF;
  localparam int PHASE_ITEMS  = 48;
  localparam int NUM_PHASES   = 12;
  localparam int DRAIN_CYCLES = MAX_BLOCKS / 8 + 8;
  localparam int CYCLE_LIMIT  = 4000000;

  logic clk = 1'b0;
  logic rst_n;

  int err_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int items_sent  = 0;
  int op_hist [4] = '{0, 0, 0, 0};
  int cur_blocks  = 32;
  bit quiet_in    = 1'b0;
  bit quiet_out   = 1'b0;

  logic [STAT_W-1:0] last_status;
  logic [IDX_W-1:0]  last_found;
  logic [CNT_W-1:0]  phase_counts [NUM_PHASES] = '{
    14'd0, 14'd37, 14'h3FFF, 14'd33, 14'd64, 14'd8191,
    14'd31, 14'd200, 14'd8192, 14'd40, 14'd1000, 14'd32
  };

  bam_cfg_if cfg_chan ();
  bam_in_if  in_chan ();
  bam_out_if out_chan ();

  block_bitmap_allocator_unit #(.MAX_BLOCKS(MAX_BLOCKS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  bam_checker #(.MAX_BLOCKS(MAX_BLOCKS)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_mon   (cfg_chan),
    .req_mon   (in_chan),
    .rsp_mon   (out_chan),
    .err_count (err_count),
    .pending   (pending),
    .checked   (checked)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses outstanding", CYCLE_LIMIT, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // hold valid between back-to-back requests; caller drops it before waiting
  task automatic send_req(input op_t op, input logic [IDX_W-1:0] idx);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.operation   <= op;
    in_chan.block_index <= idx;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    op_hist[op]++;
  endtask

  task automatic drop_req();
    in_chan.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_block_count(input logic [CNT_W-1:0] value);
    while (pending != 0) @(negedge clk);
    cfg_chan.valid       <= 1'b1;
    cfg_chan.block_count <= value;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
    cur_blocks = (int'(value) < MIN_BLOCKS) ? MIN_BLOCKS :
                 (int'(value) > MAX_BLOCKS) ? MAX_BLOCKS : int'(value);
  endtask

  function automatic logic [IDX_W-1:0] pick_block();
    int hi;
    hi = (cur_blocks < 64) ? cur_blocks : 64;
    if ($urandom_range(0, 1) == 0) return IDX_W'($urandom_range(0, hi - 1));
    return IDX_W'($urandom_range(0, cur_blocks - 1));
  endfunction

  // find the lowest free block, then claim it
  task automatic allocate();
    send_req(OP_FIND, IDX_W'($urandom_range(0, 8191)));
    drop_req();
    while (pending != 0) @(negedge clk);
    if (last_status == STATUS_OK) send_req(OP_MARK_USED, last_found);
  endtask

  task automatic random_item();
    int pick;
    int alloc_weight;
    alloc_weight = (cur_blocks <= 64) ? 45 : 20;
    pick = $urandom_range(0, 99);
    if (pick < alloc_weight) begin
      allocate();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_req(OP_FORMAT, IDX_W'($urandom_range(0, 8191)));
      end else if (pick < 23) begin
        send_req(OP_FIND, IDX_W'($urandom_range(0, 8191)));
      end else if (pick < 48) begin
        send_req(OP_MARK_USED, pick_block());
      end else if (pick < 73) begin
        send_req(OP_MARK_FREE, pick_block());
      end else if (pick < 88) begin
        send_req(op_t'($urandom_range(0, 1)),
                 (cur_blocks < MAX_BLOCKS) ? IDX_W'($urandom_range(cur_blocks, 8191))
                                           : IDX_W'($urandom_range(0, 8191)));
      end else begin
        send_req(op_t'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 8191)));
      end
    end
  endtask

  initial begin
    int stall;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = quiet_out ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      @(posedge clk);
      while (!out_chan.valid) @(posedge clk);
      last_status = out_chan.status;
      last_found  = out_chan.found_block;
    end
  end

  initial begin
    int phase_end;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.operation    = OP_MARK_USED;
    in_chan.block_index  = '0;
    cfg_chan.valid       = 1'b0;
    cfg_chan.block_count = RESET_BLOCKS;
    phase_counts[NUM_PHASES-1] = CNT_W'($urandom_range(32, 300));
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_req(OP_FIND, 13'h1FFF);
    send_req(OP_MARK_USED, 13'd0);
    send_req(OP_MARK_FREE, 13'd0);
    send_req(OP_FIND, 13'd0);
    send_req(OP_MARK_USED, 13'd0);
    send_req(OP_MARK_FREE, 13'd1);
    send_req(OP_MARK_USED, 13'd1);
    send_req(OP_MARK_USED, 13'd31);
    send_req(OP_MARK_USED, 13'd31);
    send_req(OP_MARK_USED, 13'd32);
    send_req(OP_MARK_FREE, 13'h1FFF);
    send_req(OP_MARK_USED, 13'h1FFF);
    send_req(OP_MARK_FREE, 13'd31);
    send_req(OP_MARK_FREE, 13'd31);
    send_req(OP_FORMAT, 13'h1555);
    send_req(OP_FIND, 13'h0AAA);
    drop_req();

    for (int k = 0; k < NUM_PHASES; k++) begin
      write_block_count(phase_counts[k]);
      quiet_in  = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) send_req(OP_FORMAT, IDX_W'($urandom_range(0, 8191)));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) random_item();
      drop_req();
    end

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending != 0) $display("%0d expected responses never arrived", pending);
    $display("Sent %0d requests: mark used %0d, mark free %0d, find %0d, format %0d",
             items_sent, op_hist[OP_MARK_USED], op_hist[OP_MARK_FREE], op_hist[OP_FIND],
             op_hist[OP_FORMAT]);
    $display("Checked %0d responses across %0d block-count settings", checked, NUM_PHASES + 1);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
